/* hw/rtl/izh_pkg.sv */
// izh_pkg: shared types and constants for the izhikevich neuron update block
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package izh_pkg;

  typedef logic signed [31:0] word_t;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes, from paddr[3:2]
  localparam logic [1:0] REG_RECOVERY_RATE  = 2'd0;
  localparam logic [1:0] REG_RESET_VOLTAGE  = 2'd1;
  localparam logic [1:0] REG_RECOVERY_JUMP  = 2'd2;
  localparam logic [1:0] REG_OFFSET_CURRENT = 2'd3;

  // register reset values
  localparam logic [15:0]        RATE_RST   = 16'd655;
  localparam logic signed [23:0] VRESET_RST = -24'sd2129920;
  localparam logic signed [23:0] JUMP_RST   = 24'sd262144;

  // s16.15 constants
  localparam word_t K_10_24  = 32'sd335544;
  localparam word_t K_1_256  = 32'sd128;
  localparam word_t K_5      = 32'sd163840;
  localparam word_t K_140    = 32'sd4587520;
  localparam word_t K_1_16   = 32'sd2048;
  localparam logic [15:0] K_0_05 = 16'd1638;
  localparam word_t K_RS_A   = 32'sd167772;
  localparam word_t K_FS_A   = 32'sd838861;
  localparam word_t K_B      = 32'sd1677722;
  localparam word_t K_THRESH = 32'sd983040;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DRV1,
    ST_DRV2,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_M5,
    ST_A5,
    ST_M6,
    ST_M7,
    ST_A6,
    ST_M8,
    ST_M9,
    ST_M10,
    ST_A7,
    ST_CHK,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/izh_in_if.sv */
// izh_in_if: input channel carrying the three drive currents of one timestep
// depends on izh_pkg for the word type
`default_nettype none

interface izh_in_if;
  import izh_pkg::*;

  logic  valid;
  logic  ready;
  word_t excitatory_current;
  word_t inhibitory_current;
  word_t external_current;

  modport source (
    output valid, excitatory_current, inhibitory_current, external_current,
    input  ready
  );

  modport sink (
    input  valid, excitatory_current, inhibitory_current, external_current,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/izh_out_if.sv */
// izh_out_if: result channel carrying the membrane voltage and spike flag
// depends on izh_pkg for the word type
`default_nettype none

interface izh_out_if;
  import izh_pkg::*;

  logic  valid;
  logic  ready;
  word_t membrane_voltage;
  logic  spiked;

  modport source (
    output valid, membrane_voltage, spiked,
    input  ready
  );

  modport sink (
    input  valid, membrane_voltage, spiked,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/izhikevich_neuron_euler_update.sv */
// Izhikevich neuron, one timestep per input transaction, s16.15 fixed point.
// An input transaction on in_i carries the excitatory, inhibitory and external
// currents; the block takes excitatory minus inhibitory plus external plus the
// offset current and runs SUBSTEPS semi-implicit Euler substeps on v and u,
// then presents v and a spike flag as one transaction on out_o.
// Timing: in_i.ready is high only while idle. Each item forms the drive current
// and then runs SUBSTEPS substeps before the result register is loaded; every
// substep is 18 steps of one shared 32x32 multiplier and one saturating
// adder. The next item is taken the cycle after the result is loaded.
// The result sits in an output register, so an input may be accepted while it
// waits; if a finished result finds the register still full, the sequencer
// holds until the receiver takes the earlier one.
// Configuration is written over the APB port (4 registers at 4*i); the user
// writes it only while idle, which the block does not enforce.
// Reset (rst_ni low, asynchronous) restores register defaults, v to the
// default reset voltage, u to zero, and empties the output register.
// Depends on izh_pkg, izh_in_if and izh_out_if.
`default_nettype none

module izhikevich_neuron_euler_update #(
  parameter int SUBSTEPS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  izh_in_if.sink                      in_i,
  izh_out_if.source                   out_o,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [izh_pkg::ADDR_W-1:0]   paddr,
  input  wire [izh_pkg::DATA_W-1:0]   pwdata,
  output logic [izh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import izh_pkg::*;

  localparam int CNT_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

  // configuration registers
  logic [15:0]        rate_q;
  logic signed [23:0] vreset_q;
  logic signed [23:0] jump_q;
  word_t              offset_q;

  // sequencer and datapath state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  word_t              v_q, v_d;
  word_t              u_q, u_d;
  word_t              s_q, s_d;
  word_t              t_q, t_d;
  word_t              drive_q, drive_d;
  word_t              ext_q, ext_d;
  logic               spk_q, spk_d;
  logic signed [63:0] prod_q, prod_d;

  // output register
  logic               ovalid_q, ovalid_d;
  word_t              ov_q, ov_d;
  logic               ospk_q, ospk_d;

  // shared unit
  word_t              mul_a, mul_b;
  logic signed [63:0] mul_p;
  word_t              add_a, add_b;
  logic               add_sub;
  logic signed [32:0] add_raw;
  word_t              add_r;
  logic signed [48:0] p_sh;
  word_t              psat;
  word_t              ar;

  logic               cfg_wr;
  logic               in_acc;
  logic               last_sub;
  logic               out_free;

  function automatic word_t sat49(input logic signed [48:0] x);
    if (x > 49'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -49'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  function automatic word_t sat33(input logic signed [32:0] x);
    if (x[32] != x[31]) begin
      return x[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      return x[31:0];
    end
  endfunction

  // ---------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RATE_RST;
      vreset_q <= VRESET_RST;
      jump_q   <= JUMP_RST;
      offset_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RECOVERY_RATE:  rate_q   <= pwdata[15:0];
        REG_RESET_VOLTAGE:  vreset_q <= pwdata[23:0];
        REG_RECOVERY_JUMP:  jump_q   <= pwdata[23:0];
        REG_OFFSET_CURRENT: offset_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RECOVERY_RATE:  prdata = {16'd0, rate_q};
      REG_RESET_VOLTAGE:  prdata = 32'(vreset_q);
      REG_RECOVERY_JUMP:  prdata = 32'(jump_q);
      REG_OFFSET_CURRENT: prdata = offset_q;
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // shared multiplier and saturating adder
  // ---------------------------------------------------------------
  assign ar      = (rate_q > K_0_05) ? K_FS_A : K_RS_A;
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign p_sh    = 49'(prod_q >>> 15);
  assign psat    = sat49(p_sh);
  assign add_raw = add_sub ? (33'(add_a) - 33'(add_b)) : (33'(add_a) + 33'(add_b));
  assign add_r   = sat33(add_raw);

  assign in_acc   = in_i.valid && in_i.ready;
  assign last_sub = (cnt_q == CNT_W'(SUBSTEPS - 1));
  assign out_free = !ovalid_q || out_o.ready;

  // operand selection per step
  always_comb begin
    mul_a   = v_q;
    mul_b   = K_10_24;
    add_a   = s_q;
    add_b   = t_q;
    add_sub = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        add_a   = in_i.excitatory_current;
        add_b   = in_i.inhibitory_current;
        add_sub = 1'b1;
      end
      ST_DRV1: begin
        add_a = drive_q;
        add_b = ext_q;
      end
      ST_DRV2: begin
        add_a = drive_q;
        add_b = offset_q;
      end
      ST_M1: begin
        mul_a = v_q;
        mul_b = K_10_24;
      end
      ST_M2: begin
        mul_a = psat;
        mul_b = K_1_256;
      end
      ST_M3: begin
        mul_a = psat;
        mul_b = v_q;
      end
      ST_M4: begin
        mul_a = v_q;
        mul_b = K_5;
      end
      ST_A1: begin
        add_a = psat;
        add_b = K_140;
      end
      ST_A2: begin
        add_a   = s_q;
        add_b   = u_q;
        add_sub = 1'b1;
      end
      ST_A3: begin
        add_a = s_q;
        add_b = drive_q;
      end
      ST_A4: begin
        add_a = t_q;
        add_b = s_q;
      end
      ST_M5: begin
        mul_a = s_q;
        mul_b = K_1_16;
      end
      ST_A5: begin
        add_a = v_q;
        add_b = psat;
      end
      ST_M6: begin
        mul_a = v_q;
        mul_b = K_B;
      end
      ST_M7: begin
        mul_a = psat;
        mul_b = K_1_256;
      end
      ST_A6: begin
        add_a   = psat;
        add_b   = u_q;
        add_sub = 1'b1;
      end
      ST_M8: begin
        mul_a = t_q;
        mul_b = ar;
      end
      ST_M9: begin
        mul_a = psat;
        mul_b = K_1_16;
      end
      ST_M10: begin
        mul_a = psat;
        mul_b = K_1_256;
      end
      ST_A7: begin
        add_a = u_q;
        add_b = psat;
      end
      ST_CHK: begin
        add_a = u_q;
        add_b = 32'(jump_q);
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // register updates per step
  always_comb begin
    v_d      = v_q;
    u_d      = u_q;
    s_d      = s_q;
    t_d      = t_q;
    drive_d  = drive_q;
    ext_d    = ext_q;
    spk_d    = spk_q;
    cnt_d    = cnt_q;
    prod_d   = prod_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ov_d     = ov_q;
    ospk_d   = ospk_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          drive_d = add_r;
          ext_d   = in_i.external_current;
          spk_d   = 1'b0;
          cnt_d   = '0;
        end
      end
      ST_DRV1, ST_DRV2: drive_d = add_r;
      ST_M1, ST_M2, ST_M3, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10: begin
        prod_d = mul_p;
      end
      ST_M4: begin
        t_d    = psat;  // q, kept while p is built
        prod_d = mul_p;
      end
      ST_A1, ST_A2, ST_A3, ST_A4: s_d = add_r;
      ST_A5: v_d = add_r;
      ST_A6: t_d = add_r;
      ST_A7: u_d = add_r;
      ST_CHK: begin
        if (v_q >= K_THRESH) begin
          spk_d = 1'b1;
          v_d   = 32'(vreset_q);
          u_d   = add_r;
        end
        if (!last_sub) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ov_d     = v_q;
          ospk_d   = spk_q;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_DRV1;
      ST_DRV1: state_d = ST_DRV2;
      ST_DRV2: state_d = ST_M1;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_M3;
      ST_M3:   state_d = ST_M4;
      ST_M4:   state_d = ST_A1;
      ST_A1:   state_d = ST_A2;
      ST_A2:   state_d = ST_A3;
      ST_A3:   state_d = ST_A4;
      ST_A4:   state_d = ST_M5;
      ST_M5:   state_d = ST_A5;
      ST_A5:   state_d = ST_M6;
      ST_M6:   state_d = ST_M7;
      ST_M7:   state_d = ST_A6;
      ST_A6:   state_d = ST_M8;
      ST_M8:   state_d = ST_M9;
      ST_M9:   state_d = ST_M10;
      ST_M10:  state_d = ST_A7;
      ST_A7:   state_d = ST_CHK;
      ST_CHK:  state_d = last_sub ? ST_OUT : ST_M1;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      v_q      <= 32'(VRESET_RST);
      u_q      <= '0;
      spk_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      v_q      <= v_d;
      u_q      <= u_d;
      spk_q    <= spk_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    t_q     <= t_d;
    drive_q <= drive_d;
    ext_q   <= ext_d;
    prod_q  <= prod_d;
    ov_q    <= ov_d;
    ospk_q  <= ospk_d;
  end

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = ovalid_q;
  assign out_o.membrane_voltage = ov_q;
  assign out_o.spiked           = ospk_q;

endmodule

`default_nettype wire
